// ===== src/mecanum_wheel_speed_and_power_limit_assert.svh =====
// Assertion macros for the mecanum wheel speed and power limit block
`ifndef MECANUM_WHEEL_SPEED_AND_POWER_LIMIT_ASSERT_SVH
`define MECANUM_WHEEL_SPEED_AND_POWER_LIMIT_ASSERT_SVH

// clocked assertion, off while in reset
`define MWSP_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mwsp assertion failed");

// clocked assertion, checked during reset too
`define MWSP_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("mwsp assertion failed");

`endif

// ===== src/mwsp_pkg.sv =====
// Shared constants, types and functions for the mecanum wheel speed and power limit block
package mwsp_pkg;

  localparam int unsigned SPEED_WIDTH = 16;
  localparam int unsigned WHEEL_COUNT = 4;
  localparam int unsigned CMD_W       = 15;
  localparam int unsigned TGT_W       = 17;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned LIM_W       = 15;
  localparam int unsigned PWR_W       = 12;
  localparam int unsigned BUF_W       = 11;
  localparam int unsigned BUDGET_W    = 16;
  localparam int unsigned PF_W        = 16;
  localparam int unsigned CUR_W       = 16;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_CUTOFF   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_LIMIT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_BUDGET = 4'd3;

  localparam logic [LIM_W-1:0]    SPEED_LIMIT_RST    = 15'd10000;
  localparam logic [PWR_W-1:0]    POWER_CUTOFF_RST   = 12'd600;
  localparam logic [LIM_W-1:0]    FALLBACK_LIMIT_RST = 15'd4096;
  localparam logic [BUDGET_W-1:0] CURRENT_BUDGET_RST = 16'd61536;

  localparam logic [CUR_W-1:0] CUR_MAX = 16'h7FFF;
  localparam logic [CUR_W-1:0] CUR_MIN = 16'h8000;

  typedef struct packed {
    logic [WHEEL_COUNT-1:0][TGT_W-1:0]       tgt;
    logic [WHEEL_COUNT-1:0][SPEED_WIDTH-1:0] meas;
    logic                                    over;
    logic [PF_W-1:0]                         pf;
  } mwsp_item_t;

  typedef struct packed {
    logic [WHEEL_COUNT-1:0][SPEED_WIDTH-1:0] tgt;
    logic [WHEEL_COUNT-1:0][CUR_W-1:0]       cur;
    logic                                    over;
  } mwsp_res_t;

  // buffer-energy factor, Q1.15
  function automatic logic [PF_W-1:0] buf_factor(input logic signed [BUF_W-1:0] b);
    logic [PF_W-1:0] f;
    if (b >= 11'sd40 && b < 11'sd50) f = 16'd29491;
    else if (b >= 11'sd35 && b < 11'sd40) f = 16'd24576;
    else if (b >= 11'sd30 && b < 11'sd35) f = 16'd16384;
    else if (b >= 11'sd20 && b < 11'sd30) f = 16'd8192;
    else if (b >= 11'sd10 && b < 11'sd20) f = 16'd4096;
    else if (b >= 11'sd0 && b < 11'sd10) f = 16'd1638;
    else f = 16'd32768;
    return f;
  endfunction

endpackage

// ===== src/mwsp_if.sv =====
// Channel interfaces: command items, result items and configuration writes
interface mwsp_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [mwsp_pkg::CMD_W-1:0]         vel_x;
  logic signed [mwsp_pkg::CMD_W-1:0]         vel_y;
  logic signed [mwsp_pkg::CMD_W-1:0]         yaw_rate;
  logic signed [mwsp_pkg::SPEED_WIDTH-1:0]   meas_speed_0;
  logic signed [mwsp_pkg::SPEED_WIDTH-1:0]   meas_speed_1;
  logic signed [mwsp_pkg::SPEED_WIDTH-1:0]   meas_speed_2;
  logic signed [mwsp_pkg::SPEED_WIDTH-1:0]   meas_speed_3;
  logic        [mwsp_pkg::PWR_W-1:0]         power_meas;
  logic signed [mwsp_pkg::BUF_W-1:0]         buffer_energy;
  modport source (output valid, vel_x, vel_y, yaw_rate, meas_speed_0, meas_speed_1,
                  meas_speed_2, meas_speed_3, power_meas, buffer_energy,
                  input ready);
  modport sink (input valid, vel_x, vel_y, yaw_rate, meas_speed_0, meas_speed_1,
                meas_speed_2, meas_speed_3, power_meas, buffer_energy,
                output ready);
endinterface

interface mwsp_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mwsp_pkg::SPEED_WIDTH-1:0] target_0;
  logic signed [mwsp_pkg::SPEED_WIDTH-1:0] target_1;
  logic signed [mwsp_pkg::SPEED_WIDTH-1:0] target_2;
  logic signed [mwsp_pkg::SPEED_WIDTH-1:0] target_3;
  logic signed [mwsp_pkg::CUR_W-1:0]       current_0;
  logic signed [mwsp_pkg::CUR_W-1:0]       current_1;
  logic signed [mwsp_pkg::CUR_W-1:0]       current_2;
  logic signed [mwsp_pkg::CUR_W-1:0]       current_3;
  logic                                    use_speed_loop;
  modport source (output valid, target_0, target_1, target_2, target_3, current_0,
                  current_1, current_2, current_3, use_speed_loop, input ready);
  modport sink (input valid, target_0, target_1, target_2, target_3, current_0,
                current_1, current_2, current_3, use_speed_loop, output ready);
endinterface

interface mwsp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mwsp_pkg::CFG_IDX_W-1:0]      index;
  logic [mwsp_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/mwsp_clamp.sv =====
// Speed clamp: max magnitude, then pipelined restoring divide of |t|*lim by max
module mwsp_clamp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mwsp_pkg::LIM_W-1:0]     lim_i,
  input  logic                           gate_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mwsp_pkg::mwsp_item_t           in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mwsp_pkg::mwsp_item_t           out_item_o
);
  localparam int unsigned NW  = mwsp_pkg::WHEEL_COUNT;
  localparam int unsigned MW  = mwsp_pkg::MAG_W;
  localparam int unsigned QW  = mwsp_pkg::LIM_W;
  localparam int unsigned TW  = mwsp_pkg::TGT_W;
  localparam int unsigned NS  = QW + 1;

  // stage A: magnitudes and max
  logic [MW-1:0] mag_d [NW];
  logic [MW-1:0] m01, m23, mx_d;
  logic          scale_d;

  logic                 va_q;
  mwsp_pkg::mwsp_item_t a_item_q;
  logic [MW-1:0]        a_mag_q [NW];
  logic [MW-1:0]        a_mx_q;
  logic                 a_scale_q;

  logic [NS-1:0]        v_q;
  logic [NS:0]          rdy;
  mwsp_pkg::mwsp_item_t item_q  [NS];
  logic                 scale_q [NS];
  logic [MW-1:0]        d_q     [NS];
  logic [MW-1:0]        rem_q   [NS][NW];
  logic [QW-1:0]        ql_q    [NS][NW];
  logic                 rdy_a;

  always_comb begin
    for (int w = 0; w < NW; w++) begin
      mag_d[w] = in_item_i.tgt[w][TW-1] ? MW'(-in_item_i.tgt[w]) : in_item_i.tgt[w][MW-1:0];
    end
    m01     = (mag_d[0] > mag_d[1]) ? mag_d[0] : mag_d[1];
    m23     = (mag_d[2] > mag_d[3]) ? mag_d[2] : mag_d[3];
    mx_d    = (m01 > m23) ? m01 : m23;
    scale_d = (!gate_i || in_item_i.over) && (mx_d > MW'(lim_i));
  end

  assign rdy_a      = !va_q || rdy[0];
  assign in_ready_o = rdy_a;
  assign rdy[NS]    = out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_item_q  <= in_item_i;
      a_mag_q   <= mag_d;
      a_mx_q    <= mx_d;
      a_scale_q <= scale_d;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                 pv;
    mwsp_pkg::mwsp_item_t pitem;
    logic                 pscale;
    logic [MW-1:0]        pd;
    logic [MW-1:0]        nrem [NW];
    logic [QW-1:0]        nql  [NW];

    assign rdy[k] = !v_q[k] || rdy[k+1];

    if (k == 0) begin : g_init
      logic [MW+QW-1:0] prod [NW];
      assign pv     = va_q;
      assign pitem  = a_item_q;
      assign pscale = a_scale_q;
      assign pd     = a_mx_q;
      for (genvar w = 0; w < NW; w++) begin : g_w
        assign prod[w] = a_mag_q[w] * lim_i;
        assign nrem[w] = prod[w][MW+QW-1:QW];
        assign nql[w]  = prod[w][QW-1:0];
      end
    end else begin : g_step
      assign pv     = v_q[k-1];
      assign pitem  = item_q[k-1];
      assign pscale = scale_q[k-1];
      assign pd     = d_q[k-1];
      for (genvar w = 0; w < NW; w++) begin : g_w
        logic [MW:0] tmp;
        logic        ge;
        assign tmp     = {rem_q[k-1][w], ql_q[k-1][w][QW-1]};
        assign ge      = tmp >= {1'b0, pd};
        assign nrem[w] = ge ? MW'(tmp - {1'b0, pd}) : tmp[MW-1:0];
        assign nql[w]  = {ql_q[k-1][w][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && pv) begin
        item_q[k]  <= pitem;
        scale_q[k] <= pscale;
        d_q[k]     <= pd;
        rem_q[k]   <= nrem;
        ql_q[k]    <= nql;
      end
    end
  end

  assign out_valid_o = v_q[NS-1];

  always_comb begin
    out_item_o = item_q[NS-1];
    for (int w = 0; w < NW; w++) begin
      if (scale_q[NS-1]) begin
        out_item_o.tgt[w] = item_q[NS-1].tgt[w][TW-1] ? TW'(-{2'b00, ql_q[NS-1][w]})
                                                       : {2'b00, ql_q[NS-1][w]};
      end
    end
  end

endmodule

// ===== src/mwsp_current.sv =====
// Current share: speed errors, scaled budget and pipelined restoring divide by max(sum, 4*limit)
module mwsp_current (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [mwsp_pkg::LIM_W-1:0]      lim_i,
  input  logic [mwsp_pkg::BUDGET_W-1:0]   budget_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  mwsp_pkg::mwsp_item_t            in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output mwsp_pkg::mwsp_res_t             out_res_o
);
  localparam int unsigned NW   = mwsp_pkg::WHEEL_COUNT;
  localparam int unsigned SW   = mwsp_pkg::SPEED_WIDTH;
  localparam int unsigned TW   = mwsp_pkg::TGT_W;
  localparam int unsigned EW   = TW + 1;
  localparam int unsigned EMW  = 16;
  localparam int unsigned BPW  = mwsp_pkg::BUDGET_W + mwsp_pkg::PF_W;
  localparam int unsigned HW   = BPW / 2;
  localparam int unsigned PPW  = EMW + HW;
  localparam int unsigned AW   = PPW + HW;
  localparam int unsigned QW   = mwsp_pkg::CUR_W;
  localparam int unsigned DW   = 18;
  localparam int unsigned NS   = QW + 1;
  localparam int unsigned SHR  = 15;
  localparam int unsigned APW  = AW - SHR;

  // stage 1: errors, budget times factor
  logic [EW-1:0]  err_d [NW];
  logic [EMW-1:0] emag_d [NW];
  logic           neg_d [NW];

  logic                 v1_q;
  mwsp_pkg::mwsp_item_t item1_q;
  logic [EMW-1:0]       emag1_q [NW];
  logic                 neg1_q  [NW];
  logic [BPW-1:0]       bp1_q;
  logic                 rdy1;

  // stage 2: error sum, denominator, partial products
  logic [DW-1:0]        sum_d, l4_d;
  logic                 v2_q;
  mwsp_pkg::mwsp_item_t item2_q;
  logic                 neg2_q  [NW];
  logic [PPW-1:0]       pplo2_q [NW];
  logic [PPW-1:0]       pphi2_q [NW];
  logic [DW-1:0]        den2_q;
  logic                 zero2_q;
  logic                 rdy2;

  // divide stages
  logic [NS-1:0]        v_q;
  logic [NS:0]          rdy;
  mwsp_pkg::mwsp_item_t item_q [NS];
  logic                 neg_q  [NS][NW];
  logic                 ovf_q  [NS][NW];
  logic                 zero_q [NS];
  logic [DW-1:0]        d_q    [NS];
  logic [DW-1:0]        rem_q  [NS][NW];
  logic [QW-1:0]        ql_q   [NS][NW];

  // output register
  logic                 vo_q;
  mwsp_pkg::mwsp_res_t  res_q;
  mwsp_pkg::mwsp_res_t  res_d;
  logic                 rdy_o;

  always_comb begin
    for (int w = 0; w < NW; w++) begin
      err_d[w]  = {in_item_i.tgt[w][TW-1], in_item_i.tgt[w]}
                - {{(EW-SW){in_item_i.meas[w][SW-1]}}, in_item_i.meas[w]};
      neg_d[w]  = err_d[w][EW-1];
      emag_d[w] = neg_d[w] ? EMW'(-err_d[w]) : err_d[w][EMW-1:0];
    end
  end

  assign rdy_o      = !vo_q || out_ready_i;
  assign rdy[NS]    = rdy_o;
  assign rdy2       = !v2_q || rdy[0];
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy_o) begin
        vo_q <= v_q[NS-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      item1_q <= in_item_i;
      emag1_q <= emag_d;
      neg1_q  <= neg_d;
      bp1_q   <= budget_i * in_item_i.pf;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int w = 0; w < NW; w++) begin
      sum_d = sum_d + DW'(emag1_q[w]);
    end
    l4_d = {1'b0, lim_i, 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      item2_q <= item1_q;
      neg2_q  <= neg1_q;
      den2_q  <= (sum_d > l4_d) ? sum_d : l4_d;
      zero2_q <= (sum_d == '0) || item1_q.over;
      for (int w = 0; w < NW; w++) begin
        pplo2_q[w] <= emag1_q[w] * bp1_q[HW-1:0];
        pphi2_q[w] <= emag1_q[w] * bp1_q[BPW-1:HW];
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                 pv;
    mwsp_pkg::mwsp_item_t pitem;
    logic                 pzero;
    logic [DW-1:0]        pd;
    logic                 pneg [NW];
    logic                 novf [NW];
    logic [DW-1:0]        nrem [NW];
    logic [QW-1:0]        nql  [NW];

    assign rdy[k] = !v_q[k] || rdy[k+1];

    if (k == 0) begin : g_init
      assign pv    = v2_q;
      assign pitem = item2_q;
      assign pzero = zero2_q;
      assign pd    = den2_q;
      for (genvar w = 0; w < NW; w++) begin : g_w
        logic [AW-1:0]  sum_pp;
        logic [APW-1:0] ap;
        logic [APW-QW-1:0] hi;
        assign sum_pp  = {pphi2_q[w], {HW{1'b0}}} + AW'(pplo2_q[w]);
        assign ap      = sum_pp[AW-1:SHR];
        assign hi      = ap[APW-1:QW];
        assign pneg[w] = neg2_q[w];
        assign novf[w] = DW'(hi) >= den2_q;
        assign nrem[w] = DW'(hi);
        assign nql[w]  = ap[QW-1:0];
      end
    end else begin : g_step
      assign pv    = v_q[k-1];
      assign pitem = item_q[k-1];
      assign pzero = zero_q[k-1];
      assign pd    = d_q[k-1];
      for (genvar w = 0; w < NW; w++) begin : g_w
        logic [DW:0] tmp;
        logic        ge;
        assign tmp     = {rem_q[k-1][w], ql_q[k-1][w][QW-1]};
        assign ge      = tmp >= {1'b0, pd};
        assign pneg[w] = neg_q[k-1][w];
        assign novf[w] = ovf_q[k-1][w];
        assign nrem[w] = ge ? DW'(tmp - {1'b0, pd}) : tmp[DW-1:0];
        assign nql[w]  = {ql_q[k-1][w][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && pv) begin
        item_q[k] <= pitem;
        zero_q[k] <= pzero;
        d_q[k]    <= pd;
        neg_q[k]  <= pneg;
        ovf_q[k]  <= novf;
        rem_q[k]  <= nrem;
        ql_q[k]   <= nql;
      end
    end
  end

  // sign and saturation
  always_comb begin
    res_d.over = item_q[NS-1].over;
    for (int w = 0; w < NW; w++) begin
      res_d.tgt[w] = item_q[NS-1].tgt[w][SW-1:0];
      if (zero_q[NS-1]) begin
        res_d.cur[w] = '0;
      end else if (!neg_q[NS-1][w]) begin
        res_d.cur[w] = (ovf_q[NS-1][w] || ql_q[NS-1][w][QW-1]) ? mwsp_pkg::CUR_MAX
                                                                : ql_q[NS-1][w];
      end else begin
        res_d.cur[w] = (ovf_q[NS-1][w] || ql_q[NS-1][w] > mwsp_pkg::CUR_MIN)
                     ? mwsp_pkg::CUR_MIN : QW'(-ql_q[NS-1][w]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && v_q[NS-1]) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_res_o   = res_q;

endmodule

// ===== src/mecanum_wheel_speed_and_power_limit.sv =====
// Top level: mecanum wheel mixing, speed clamps and buffer-energy current limit
//
//  channel  dir  handshake       payload
//  cfg_i    in   valid/ready     index, data (register write)
//  in_i     in   valid/ready     chassis command, measured speeds, power, buffer
//  out_o    out  valid/ready     targets, currents, use_speed_loop
//
// One item per cycle while out_o does not stall; the two clamps use 15-step dividers
// and the current share uses a restoring divider, one quotient bit per stage.
// Every stage has its own valid bit; a stall at out_o fills bubbles first.
// Reset clears all valid bits and loads the register reset values.
// cfg_i.ready is always high.
module mecanum_wheel_speed_and_power_limit (
  input  logic         clk_i,
  input  logic         rst_ni,
  mwsp_cfg_if.sink     cfg_i,
  mwsp_in_if.sink      in_i,
  mwsp_out_if.source   out_o
);
  localparam int unsigned CW = mwsp_pkg::CMD_W;
  localparam int unsigned TW = mwsp_pkg::TGT_W;

  logic [mwsp_pkg::LIM_W-1:0]    speed_limit_q;
  logic [mwsp_pkg::PWR_W-1:0]    power_cutoff_q;
  logic [mwsp_pkg::LIM_W-1:0]    fallback_limit_q;
  logic [mwsp_pkg::BUDGET_W-1:0] current_budget_q;

  logic [TW-1:0]         x, y, w;
  mwsp_pkg::mwsp_item_t  mix_d, mix_q;
  logic                  mix_v_q, mix_rdy;

  logic                  c1_rdy, c1_v, c2_rdy, c2_v, cur_rdy;
  mwsp_pkg::mwsp_item_t  c1_item, c2_item;
  mwsp_pkg::mwsp_res_t   res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q    <= mwsp_pkg::SPEED_LIMIT_RST;
      power_cutoff_q   <= mwsp_pkg::POWER_CUTOFF_RST;
      fallback_limit_q <= mwsp_pkg::FALLBACK_LIMIT_RST;
      current_budget_q <= mwsp_pkg::CURRENT_BUDGET_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mwsp_pkg::REG_SPEED_LIMIT:    speed_limit_q    <= cfg_i.data[mwsp_pkg::LIM_W-1:0];
        mwsp_pkg::REG_POWER_CUTOFF:   power_cutoff_q   <= cfg_i.data[mwsp_pkg::PWR_W-1:0];
        mwsp_pkg::REG_FALLBACK_LIMIT: fallback_limit_q <= cfg_i.data[mwsp_pkg::LIM_W-1:0];
        mwsp_pkg::REG_CURRENT_BUDGET: current_budget_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // mixing
  always_comb begin
    x = {{(TW-CW){in_i.vel_x[CW-1]}}, in_i.vel_x};
    y = {{(TW-CW){in_i.vel_y[CW-1]}}, in_i.vel_y};
    w = {{(TW-CW){in_i.yaw_rate[CW-1]}}, in_i.yaw_rate};
    mix_d.tgt[0]  = x + y + w;
    mix_d.tgt[1]  = x - y + w;
    mix_d.tgt[2]  = w - x - y;
    mix_d.tgt[3]  = w - x + y;
    mix_d.meas[0] = in_i.meas_speed_0;
    mix_d.meas[1] = in_i.meas_speed_1;
    mix_d.meas[2] = in_i.meas_speed_2;
    mix_d.meas[3] = in_i.meas_speed_3;
    mix_d.over    = in_i.power_meas > power_cutoff_q;
    mix_d.pf      = mwsp_pkg::buf_factor(in_i.buffer_energy);
  end

  assign mix_rdy    = !mix_v_q || c1_rdy;
  assign in_i.ready = mix_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_v_q <= 1'b0;
    end else if (mix_rdy) begin
      mix_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mix_rdy && in_i.valid) begin
      mix_q <= mix_d;
    end
  end

  mwsp_clamp u_clamp_speed (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (speed_limit_q),
    .gate_i      (1'b0),
    .in_valid_i  (mix_v_q),
    .in_ready_o  (c1_rdy),
    .in_item_i   (mix_q),
    .out_valid_o (c1_v),
    .out_ready_i (c2_rdy),
    .out_item_o  (c1_item)
  );

  mwsp_clamp u_clamp_fallback (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (fallback_limit_q),
    .gate_i      (1'b1),
    .in_valid_i  (c1_v),
    .in_ready_o  (c2_rdy),
    .in_item_i   (c1_item),
    .out_valid_o (c2_v),
    .out_ready_i (cur_rdy),
    .out_item_o  (c2_item)
  );

  mwsp_current u_current (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (speed_limit_q),
    .budget_i    (current_budget_q),
    .in_valid_i  (c2_v),
    .in_ready_o  (cur_rdy),
    .in_item_i   (c2_item),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (res)
  );

  assign out_o.target_0       = res.tgt[0];
  assign out_o.target_1       = res.tgt[1];
  assign out_o.target_2       = res.tgt[2];
  assign out_o.target_3       = res.tgt[3];
  assign out_o.current_0      = res.cur[0];
  assign out_o.current_1      = res.cur[1];
  assign out_o.current_2      = res.cur[2];
  assign out_o.current_3      = res.cur[3];
  assign out_o.use_speed_loop = res.over;

endmodule

// ===== src/mwsp_checker.sv =====
// Port checker for the mecanum wheel speed and power limit block, with its bind
`include "mecanum_wheel_speed_and_power_limit_assert.svh"

module mwsp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             use_speed_loop_i,
  input logic [mwsp_pkg::SPEED_WIDTH-1:0] target_0_i,
  input logic [mwsp_pkg::SPEED_WIDTH-1:0] target_1_i,
  input logic [mwsp_pkg::SPEED_WIDTH-1:0] target_2_i,
  input logic [mwsp_pkg::SPEED_WIDTH-1:0] target_3_i,
  input logic [mwsp_pkg::CUR_W-1:0]       current_0_i,
  input logic [mwsp_pkg::CUR_W-1:0]       current_1_i,
  input logic [mwsp_pkg::CUR_W-1:0]       current_2_i,
  input logic [mwsp_pkg::CUR_W-1:0]       current_3_i
);

  logic cur_zero;
  logic tgt_ok;

  assign cur_zero = (current_0_i == '0) && (current_1_i == '0) &&
                    (current_2_i == '0) && (current_3_i == '0);
  assign tgt_ok   = (target_0_i != mwsp_pkg::CUR_MIN) && (target_1_i != mwsp_pkg::CUR_MIN) &&
                    (target_2_i != mwsp_pkg::CUR_MIN) && (target_3_i != mwsp_pkg::CUR_MIN);

  `MWSP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)

  `MWSP_ASSERT(a_speed_loop_zero, clk_i, rst_ni, out_valid_i && use_speed_loop_i |-> cur_zero)

  `MWSP_ASSERT(a_target_range, clk_i, rst_ni, out_valid_i |-> tgt_ok)

  `MWSP_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_i)

endmodule

bind mecanum_wheel_speed_and_power_limit mwsp_checker u_mwsp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .use_speed_loop_i (out_o.use_speed_loop),
  .target_0_i       (out_o.target_0),
  .target_1_i       (out_o.target_1),
  .target_2_i       (out_o.target_2),
  .target_3_i       (out_o.target_3),
  .current_0_i      (out_o.current_0),
  .current_1_i      (out_o.current_1),
  .current_2_i      (out_o.current_2),
  .current_3_i      (out_o.current_3)
);
